>>> design/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared sizes, codes and types for the strongly connected component counter.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int MAX_V  = 1024;
    localparam int MAX_E  = 4096;
    localparam int VW     = $clog2(MAX_V);
    localparam int EW     = $clog2(MAX_E);
    localparam int LW     = EW + 1;
    localparam int OW     = VW + 1;
    localparam int CFG_AW = 3;

    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_E);
    localparam logic [OW-1:0] MAX_V_O   = OW'(MAX_V);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic REG_VCOUNT = 1'b0;

    typedef logic [VW-1:0] vtx_t;
    typedef logic [LW-1:0] link_t;
    typedef logic [OW-1:0] ord_t;

    typedef struct packed {
        vtx_t  vtx;
        link_t link;
    } walk_t;

endpackage

>>> design/scc_counter.sv
// ----------------------------------------------------------------------------
// scc_counter
// Tarjan strongly connected component counter over edges held in RAM lists.
// ----------------------------------------------------------------------------
//  channel   dir  words
//  s_*       in   edge load (tuser 0) or start of a count (tuser 1)
//  m_*       out  one word per start: component total, drop flag
//  apb       cfg  vertex count at address 0
//
//  Edge load: first-edge RAM read, then list write.
//  Count: scan each vertex, enter unvisited ones, walk their edges, pop the
//  component at each root and return to the parent, paced by the RAM reads.
//  After reset and after every count a pass clears all 1024 vertex entries,
//  with s_tready low. A full output register holds the next count at its end.
// ----------------------------------------------------------------------------
module scc_counter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,  // edge_source, edge_target
    input  logic                       s_tuser,  // op
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,  // component_total, edge_dropped
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [scc_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    typedef enum logic [16:0] {
        S_CLEAR    = 17'b00000000000000001,
        S_IDLE     = 17'b00000000000000010,
        S_LOAD_W   = 17'b00000000000000100,
        S_SCAN     = 17'b00000000000001000,
        S_SCAN_CHK = 17'b00000000000010000,
        S_ENTER    = 17'b00000000000100000,
        S_ENTER2   = 17'b00000000001000000,
        S_EDGE     = 17'b00000000010000000,
        S_EDGE2    = 17'b00000000100000000,
        S_EDGE3    = 17'b00000001000000000,
        S_FIN      = 17'b00000010000000000,
        S_POPC     = 17'b00000100000000000,
        S_POPC2    = 17'b00001000000000000,
        S_RET      = 17'b00010000000000000,
        S_RET2     = 17'b00100000000000000,
        S_RET3     = 17'b01000000000000000,
        S_DONE     = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    scc_pkg::ord_t  vcount, n_eff;
    scc_pkg::ord_t  clr_reg, clr_next;
    scc_pkg::ord_t  scan_reg, scan_next;
    scc_pkg::ord_t  nord_reg, nord_next;
    scc_pkg::ord_t  cnt_reg, cnt_next;
    scc_pkg::ord_t  cdep_reg, cdep_next;
    scc_pkg::ord_t  wdep_reg, wdep_next;
    scc_pkg::link_t edges_reg, edges_next;
    logic           drop_reg, drop_next;
    scc_pkg::vtx_t  src_reg, src_next;
    scc_pkg::vtx_t  dst_reg, dst_next;
    scc_pkg::vtx_t  ent_reg, ent_next;
    scc_pkg::vtx_t  cv_reg, cv_next;
    scc_pkg::link_t ce_reg, ce_next;
    scc_pkg::ord_t  cord_reg, cord_next;
    scc_pkg::ord_t  clow_reg, clow_next;
    scc_pkg::ord_t  chlow_reg, chlow_next;
    logic           mv_reg, mv_next;
    logic [11:0]    mdata_reg, mdata_next;

    logic                          tgt_we, lnk_we, fst_we, ord_we, low_we, stk_we;
    logic                          cmp_we, wlk_we;
    logic [scc_pkg::EW-1:0]        e_waddr, e_raddr;
    scc_pkg::vtx_t                 tgt_rdata;
    scc_pkg::link_t                lnk_rdata;
    scc_pkg::vtx_t                 fst_waddr, fst_raddr, ord_waddr, ord_raddr;
    scc_pkg::vtx_t                 low_waddr, low_raddr, stk_waddr, stk_raddr;
    scc_pkg::vtx_t                 cmp_waddr, cmp_raddr, wlk_waddr, wlk_raddr;
    scc_pkg::link_t                fst_wdata, fst_rdata;
    scc_pkg::ord_t                 ord_wdata, ord_rdata, low_rdata;
    logic                          stk_wdata, stk_rdata;
    scc_pkg::vtx_t                 cmp_rdata;
    scc_pkg::walk_t                wlk_wdata, wlk_rdata;
    scc_pkg::vtx_t                 in_src, in_dst;

    scc_apb u_apb (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .vertex_count (vcount)
    );

    scc_ram #(.Width(scc_pkg::VW), .Depth(scc_pkg::MAX_E)) u_tgt (
        .clk(clk), .we(tgt_we), .waddr(e_waddr), .wdata(dst_reg),
        .raddr(e_raddr), .rdata(tgt_rdata));
    scc_ram #(.Width(scc_pkg::LW), .Depth(scc_pkg::MAX_E)) u_lnk (
        .clk(clk), .we(lnk_we), .waddr(e_waddr), .wdata(fst_rdata),
        .raddr(e_raddr), .rdata(lnk_rdata));
    scc_ram #(.Width(scc_pkg::LW), .Depth(scc_pkg::MAX_V)) u_fst (
        .clk(clk), .we(fst_we), .waddr(fst_waddr), .wdata(fst_wdata),
        .raddr(fst_raddr), .rdata(fst_rdata));
    scc_ram #(.Width(scc_pkg::OW), .Depth(scc_pkg::MAX_V)) u_ord (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata));
    scc_ram #(.Width(scc_pkg::OW), .Depth(scc_pkg::MAX_V)) u_low (
        .clk(clk), .we(low_we), .waddr(low_waddr), .wdata(clow_reg),
        .raddr(low_raddr), .rdata(low_rdata));
    scc_ram #(.Width(1), .Depth(scc_pkg::MAX_V)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata));
    scc_ram #(.Width(scc_pkg::VW), .Depth(scc_pkg::MAX_V)) u_cmp (
        .clk(clk), .we(cmp_we), .waddr(cmp_waddr), .wdata(ent_reg),
        .raddr(cmp_raddr), .rdata(cmp_rdata));
    scc_ram #(.Width($bits(scc_pkg::walk_t)), .Depth(scc_pkg::MAX_V)) u_wlk (
        .clk(clk), .we(wlk_we), .waddr(wlk_waddr), .wdata(wlk_wdata),
        .raddr(wlk_raddr), .rdata(wlk_rdata));

    assign n_eff   = (vcount > scc_pkg::MAX_V_O) ? scc_pkg::MAX_V_O : vcount;
    assign in_src  = s_tdata[scc_pkg::VW-1:0];
    assign in_dst  = s_tdata[2*scc_pkg::VW-1:scc_pkg::VW];
    assign s_tready = (state_reg == S_IDLE);

    // memory addressing
    assign e_waddr   = edges_reg[scc_pkg::EW-1:0];
    assign e_raddr   = ce_reg[scc_pkg::EW-1:0];
    assign tgt_we    = (state_reg == S_LOAD_W);
    assign lnk_we    = (state_reg == S_LOAD_W);

    assign fst_we    = (state_reg == S_LOAD_W) || (state_reg == S_CLEAR);
    assign fst_waddr = (state_reg == S_CLEAR) ? clr_reg[scc_pkg::VW-1:0] : src_reg;
    assign fst_wdata = (state_reg == S_CLEAR) ? scc_pkg::NULL_LINK : edges_reg;
    assign fst_raddr = (state_reg == S_IDLE) ? in_src : ent_reg;

    assign ord_we    = (state_reg == S_ENTER) || (state_reg == S_CLEAR);
    assign ord_waddr = (state_reg == S_CLEAR) ? clr_reg[scc_pkg::VW-1:0] : ent_reg;
    assign ord_wdata = (state_reg == S_CLEAR) ? '0 : nord_reg;

    assign stk_we    = (state_reg == S_ENTER) || (state_reg == S_CLEAR)
                       || (state_reg == S_POPC2);
    assign stk_waddr = (state_reg == S_CLEAR) ? clr_reg[scc_pkg::VW-1:0] :
                       (state_reg == S_POPC2) ? cmp_rdata : ent_reg;
    assign stk_wdata = (state_reg == S_ENTER);
    assign stk_raddr = tgt_rdata;

    assign low_we    = (state_reg == S_EDGE3) && (ord_rdata == '0);
    assign low_waddr = cv_reg;
    assign low_raddr = wlk_rdata.vtx;

    assign cmp_we    = (state_reg == S_ENTER);
    assign cmp_waddr = cdep_reg[scc_pkg::VW-1:0];
    assign cmp_raddr = cdep_reg[scc_pkg::VW-1:0] - 1'b1;

    assign wlk_we    = low_we;
    assign wlk_waddr = wdep_reg[scc_pkg::VW-1:0];
    assign wlk_wdata = '{vtx: cv_reg, link: ce_reg};
    assign wlk_raddr = wdep_reg[scc_pkg::VW-1:0] - 1'b1;

    always_comb
    begin
        case (state_reg)
            S_SCAN:  ord_raddr = scan_reg[scc_pkg::VW-1:0];
            S_EDGE2: ord_raddr = tgt_rdata;
            default: ord_raddr = wlk_rdata.vtx;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        scan_next  = scan_reg;
        nord_next  = nord_reg;
        cnt_next   = cnt_reg;
        cdep_next  = cdep_reg;
        wdep_next  = wdep_reg;
        edges_next = edges_reg;
        drop_next  = drop_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        ent_next   = ent_reg;
        cv_next    = cv_reg;
        ce_next    = ce_reg;
        cord_next  = cord_reg;
        clow_next  = clow_reg;
        chlow_next = chlow_reg;
        mv_next    = mv_reg && !m_tready;
        mdata_next = mdata_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == scc_pkg::MAX_V_O - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    src_next = in_src;
                    dst_next = in_dst;
                    if (s_tuser == scc_pkg::OP_START)
                    begin
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                    else if ((11'(in_src) >= n_eff) || (11'(in_dst) >= n_eff)
                             || edges_reg[scc_pkg::EW])
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_LOAD_W;
                    end
                end
            end
            S_LOAD_W:
            begin
                edges_next = edges_reg + 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                state_next = (scan_reg == n_eff) ? S_DONE : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (ord_rdata == '0)
                begin
                    ent_next   = scan_reg[scc_pkg::VW-1:0];
                    state_next = S_ENTER;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_ENTER:
            begin
                cdep_next  = cdep_reg + 1'b1;
                state_next = S_ENTER2;
            end
            S_ENTER2:
            begin
                cv_next    = ent_reg;
                ce_next    = fst_rdata;
                cord_next  = nord_reg;
                clow_next  = nord_reg;
                nord_next  = nord_reg + 1'b1;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                state_next = ce_reg[scc_pkg::EW] ? S_FIN : S_EDGE2;
            end
            S_EDGE2:
            begin
                ce_next    = lnk_rdata;
                ent_next   = tgt_rdata;
                state_next = S_EDGE3;
            end
            S_EDGE3:
            begin
                if (ord_rdata == '0)
                begin
                    wdep_next  = wdep_reg + 1'b1;
                    state_next = S_ENTER;
                end
                else
                begin
                    if (stk_rdata && (ord_rdata < clow_reg))
                    begin
                        clow_next = ord_rdata;
                    end
                    state_next = S_EDGE;
                end
            end
            S_FIN:
            begin
                if (clow_reg == cord_reg)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_POPC;
                end
                else
                begin
                    state_next = S_RET;
                end
            end
            S_POPC:
            begin
                if (cdep_reg == '0)
                begin
                    state_next = S_RET;
                end
                else
                begin
                    cdep_next  = cdep_reg - 1'b1;
                    state_next = S_POPC2;
                end
            end
            S_POPC2:
            begin
                state_next = (cmp_rdata == cv_reg) ? S_RET : S_POPC;
            end
            S_RET:
            begin
                if (wdep_reg == '0)
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_RET2;
                end
            end
            S_RET2:
            begin
                chlow_next = clow_reg;
                cv_next    = wlk_rdata.vtx;
                ce_next    = wlk_rdata.link;
                wdep_next  = wdep_reg - 1'b1;
                state_next = S_RET3;
            end
            S_RET3:
            begin
                cord_next  = ord_rdata;
                clow_next  = (chlow_reg < low_rdata) ? chlow_reg : low_rdata;
                state_next = S_EDGE;
            end
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    mdata_next = {drop_reg, cnt_reg};
                    cnt_next   = '0;
                    nord_next  = 11'd1;
                    edges_next = '0;
                    drop_next  = 1'b0;
                    cdep_next  = '0;
                    wdep_next  = '0;
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            scan_reg  <= '0;
            nord_reg  <= 11'd1;
            cnt_reg   <= '0;
            cdep_reg  <= '0;
            wdep_reg  <= '0;
            edges_reg <= '0;
            drop_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            scan_reg  <= scan_next;
            nord_reg  <= nord_next;
            cnt_reg   <= cnt_next;
            cdep_reg  <= cdep_next;
            wdep_reg  <= wdep_next;
            edges_reg <= edges_next;
            drop_reg  <= drop_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        ent_reg   <= ent_next;
        cv_reg    <= cv_next;
        ce_reg    <= ce_next;
        cord_reg  <= cord_next;
        clow_reg  <= clow_next;
        chlow_reg <= chlow_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'd0, mdata_reg};

    a_cdep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cdep_reg <= scc_pkg::MAX_V_O)
        else $error("component stack overflow");

    a_fin_on_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (cdep_reg != '0))
        else $error("finished vertex not on component stack");

    a_low_le_ord: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (clow_reg <= cord_reg))
        else $error("low link above visit order");

    a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edges_reg <= scc_pkg::NULL_LINK)
        else $error("edge count overflow");

endmodule

>>> design/scc_ram.sv
// ----------------------------------------------------------------------------
// scc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/scc_apb.sv
// ----------------------------------------------------------------------------
// scc_apb
// APB register file holding the vertex count.
// ----------------------------------------------------------------------------
module scc_apb (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [scc_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output scc_pkg::ord_t              vertex_count
);

    scc_pkg::ord_t vcount_reg;
    scc_pkg::ord_t vcount_next;
    logic          sel_vcount;

    assign sel_vcount = (paddr[2] == scc_pkg::REG_VCOUNT);
    assign pready     = 1'b1;

    always_comb
    begin
        vcount_next = vcount_reg;
        if (psel && penable && pwrite && sel_vcount)
        begin
            vcount_next = pwdata[scc_pkg::OW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
        end
        else
        begin
            vcount_reg <= vcount_next;
        end
    end

    assign prdata       = sel_vcount ? {{(32-scc_pkg::OW){1'b0}}, vcount_reg} : 32'd0;
    assign vertex_count = vcount_reg;

endmodule
